// ===== rtl/pfs_pkg.sv =====
// shared types, constants and the per-entry fade step for the palette fade stepper
`default_nettype none

package pfs_pkg;

  // palette depth and the address width that follows from it
  localparam int PAL_ENTRIES = 64;
  localparam int ADDR_W      = $clog2(PAL_ENTRIES);

  // field widths fixed by the item format
  localparam int TYPE_W  = 2;
  localparam int INDEX_W = 6;
  localparam int COLOR_W = 12;
  localparam int SPEED_W = 8;
  localparam int NUM_CHAN = 3;

  // 3-bit channel fields of a 0BGR word and one step of each
  localparam logic [COLOR_W-1:0] CHAN_MASK [NUM_CHAN] = '{12'h00E, 12'h0E0, 12'hE00};
  localparam logic [COLOR_W-1:0] CHAN_UNIT [NUM_CHAN] = '{12'h002, 12'h020, 12'h200};

  typedef enum logic [TYPE_W-1:0] {
    REQ_WR_CUR = 2'd0,
    REQ_WR_TGT = 2'd1,
    REQ_START  = 2'd2,
    REQ_TICK   = 2'd3
  } req_type_t;

  typedef struct packed {
    logic               moved;
    logic [COLOR_W-1:0] color;
  } step_res_t;

  // move every channel one unit toward the target, low bits kept
  function automatic step_res_t step_color(input logic [COLOR_W-1:0] cur,
                                           input logic [COLOR_W-1:0] tgt);
    step_res_t          res;
    logic [COLOR_W-1:0] a;
    logic [COLOR_W-1:0] b;
    res.moved = 1'b0;
    res.color = cur;
    for (int c = 0; c < NUM_CHAN; c++) begin
      a = cur & CHAN_MASK[c];
      b = tgt & CHAN_MASK[c];
      if (a < b) begin
        res.color = res.color + CHAN_UNIT[c];
        res.moved = 1'b1;
      end else if (a > b) begin
        res.color = res.color - CHAN_UNIT[c];
        res.moved = 1'b1;
      end
    end
    return res;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/pfs_if.sv =====
// request and result channel interfaces of the palette fade stepper
`default_nettype none

interface pfs_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  req_type;
  logic [5:0]  entry_index;
  logic [11:0] color;

  modport source (output valid, output req_type, output entry_index, output color,
                  input ready);
  modport sink   (input valid, input req_type, input entry_index, input color,
                  output ready);
endinterface

interface pfs_res_if;
  logic        valid;
  logic        ready;
  logic        fading;
  logic        is_entry;
  logic [5:0]  out_index;
  logic [11:0] out_color;
  logic        last;

  modport source (output valid, output fading, output is_entry, output out_index,
                  output out_color, output last, input ready);
  modport sink   (input valid, input fading, input is_entry, input out_index,
                  input out_color, input last, output ready);
endinterface

`default_nettype wire

// ===== rtl/palette_fade_stepper.sv =====
// Palette fade stepper: current and target palettes in block memories, one
// read-modify-write pass per fade step. A tick that triggers a step walks
// the palette once through the shared memory read port, one entry per
// cycle; if nothing moved it then gives one status beat, otherwise a second
// pass reads all entries back out at one beat per cycle while the result
// side takes them (a stalled beat holds the pass). Requests are taken only
// between these passes; a finished beat may still wait in the output
// register while the next request enters. Both palettes read as zero after
// reset through per-entry valid flags, so no clearing pass is needed. The
// fade speed (speed_r) is written through cfg_we.
`default_nettype none

module palette_fade_stepper
  import pfs_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  pfs_req_if.sink                 in_req,
  pfs_res_if.source               out_res,
  input  wire logic               cfg_we,
  input  wire logic [SPEED_W-1:0] cfg_wdata
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_STEP = 4'b0010,
    S_EMIT = 4'b0100,
    S_STAT = 4'b1000
  } state_t;

  localparam logic [ADDR_W-1:0] LAST_IDX = ADDR_W'(PAL_ENTRIES - 1);

  // control state
  state_t               state_r, state_nxt;
  logic                 fade_r, fade_nxt;
  logic [SPEED_W-1:0]   tick_r, tick_nxt;
  logic [SPEED_W-1:0]   speed_r;
  logic [ADDR_W-1:0]    ptr_r, ptr_nxt;
  logic                 idone_r, idone_nxt;
  logic                 st_v_r, st_v_nxt;
  logic [ADDR_W-1:0]    st_idx_r, st_idx_nxt;
  logic                 changed_r, changed_nxt;
  logic                 pend_r, pend_nxt;
  logic [ADDR_W-1:0]    pend_idx_r, pend_idx_nxt;
  logic [PAL_ENTRIES-1:0] cur_vld_r, tgt_vld_r;

  // output register
  logic                 ov_r, ov_nxt;
  logic                 o_fading_r, o_fading_nxt;
  logic                 o_entry_r, o_entry_nxt;
  logic [INDEX_W-1:0]   o_index_r, o_index_nxt;
  logic [COLOR_W-1:0]   o_color_r, o_color_nxt;
  logic                 o_last_r, o_last_nxt;

  // memories and their ports
  logic [COLOR_W-1:0]   cur_mem [PAL_ENTRIES];
  logic [COLOR_W-1:0]   tgt_mem [PAL_ENTRIES];
  logic                 rd_en;
  logic [ADDR_W-1:0]    rd_addr;
  logic [COLOR_W-1:0]   cur_q_r, tgt_q_r;
  logic                 cur_qv_r, tgt_qv_r;
  logic                 cur_we, tgt_we;
  logic [ADDR_W-1:0]    wr_addr;
  logic [COLOR_W-1:0]   wr_data;

  logic                 in_acc;
  logic                 idx_ok;
  logic                 out_free;
  logic                 move;
  logic                 issue;
  logic [SPEED_W-1:0]   tick_inc;
  logic [COLOR_W-1:0]   cur_q;
  logic [COLOR_W-1:0]   tgt_q;
  step_res_t            step;

  assign in_req.ready = (state_r == S_IDLE);
  assign in_acc       = in_req.valid && in_req.ready;
  assign idx_ok       = 32'(in_req.entry_index) < PAL_ENTRIES;
  assign out_free     = !ov_r || out_res.ready;
  assign tick_inc     = tick_r + SPEED_W'(1);

  // never-written entries read as zero
  assign cur_q = cur_qv_r ? cur_q_r : '0;
  assign tgt_q = tgt_qv_r ? tgt_q_r : '0;
  assign step  = step_color(cur_q, tgt_q);

  assign out_res.valid     = ov_r;
  assign out_res.fading    = o_fading_r;
  assign out_res.is_entry  = o_entry_r;
  assign out_res.out_index = o_index_r;
  assign out_res.out_color = o_color_r;
  assign out_res.last      = o_last_r;

  // sequencer, step datapath and output loading
  always_comb begin
    state_nxt    = state_r;
    fade_nxt     = fade_r;
    tick_nxt     = tick_r;
    ptr_nxt      = ptr_r;
    idone_nxt    = idone_r;
    st_v_nxt     = 1'b0;
    st_idx_nxt   = st_idx_r;
    changed_nxt  = changed_r;
    pend_nxt     = pend_r;
    pend_idx_nxt = pend_idx_r;
    ov_nxt       = ov_r && !out_res.ready;
    o_fading_nxt = o_fading_r;
    o_entry_nxt  = o_entry_r;
    o_index_nxt  = o_index_r;
    o_color_nxt  = o_color_r;
    o_last_nxt   = o_last_r;
    rd_en        = 1'b0;
    rd_addr      = ptr_r;
    cur_we       = 1'b0;
    tgt_we       = 1'b0;
    wr_addr      = ADDR_W'(in_req.entry_index);
    wr_data      = in_req.color;
    move         = 1'b0;
    issue        = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          unique case (req_type_t'(in_req.req_type))
            REQ_WR_CUR: cur_we = idx_ok;
            REQ_WR_TGT: tgt_we = idx_ok;
            REQ_START: begin
              fade_nxt = 1'b1;
              tick_nxt = '0;
            end
            REQ_TICK: begin
              if (fade_r) begin
                if (tick_inc < speed_r) begin
                  tick_nxt = tick_inc;
                end else begin
                  tick_nxt    = '0;
                  ptr_nxt     = '0;
                  idone_nxt   = 1'b0;
                  changed_nxt = 1'b0;
                  state_nxt   = S_STEP;
                end
              end
            end
            default: ;
          endcase
        end
      end

      S_STEP: begin
        // read one entry per cycle
        if (!idone_r) begin
          rd_en      = 1'b1;
          st_v_nxt   = 1'b1;
          st_idx_nxt = ptr_r;
          if (ptr_r == LAST_IDX) begin
            ptr_nxt   = '0;
            idone_nxt = 1'b1;
          end else begin
            ptr_nxt = ptr_r + ADDR_W'(1);
          end
        end
        // write back the stepped entry read last cycle
        if (st_v_r) begin
          cur_we  = 1'b1;
          wr_addr = st_idx_r;
          wr_data = step.color;
          if (step.moved) begin
            changed_nxt = 1'b1;
          end
          if (st_idx_r == LAST_IDX) begin
            ptr_nxt   = '0;
            idone_nxt = 1'b0;
            if (changed_r || step.moved) begin
              pend_nxt  = 1'b0;
              state_nxt = S_EMIT;
            end else begin
              fade_nxt  = 1'b0;
              state_nxt = S_STAT;
            end
          end
        end
      end

      S_EMIT: begin
        move  = pend_r && out_free;
        issue = !idone_r && (!pend_r || move);
        if (move) begin
          ov_nxt       = 1'b1;
          o_fading_nxt = 1'b1;
          o_entry_nxt  = 1'b1;
          o_index_nxt  = INDEX_W'(pend_idx_r);
          o_color_nxt  = cur_q;
          o_last_nxt   = (pend_idx_r == LAST_IDX);
          pend_nxt     = 1'b0;
        end
        if (issue) begin
          rd_en        = 1'b1;
          pend_nxt     = 1'b1;
          pend_idx_nxt = ptr_r;
          if (ptr_r == LAST_IDX) begin
            ptr_nxt   = '0;
            idone_nxt = 1'b1;
          end else begin
            ptr_nxt = ptr_r + ADDR_W'(1);
          end
        end
        if (idone_r && !pend_r) begin
          state_nxt = S_IDLE;
        end
      end

      S_STAT: begin
        // fade finished: one status beat
        if (out_free) begin
          ov_nxt       = 1'b1;
          o_fading_nxt = 1'b0;
          o_entry_nxt  = 1'b0;
          o_index_nxt  = '0;
          o_color_nxt  = '0;
          o_last_nxt   = 1'b1;
          state_nxt    = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      fade_r    <= 1'b0;
      tick_r    <= '0;
      speed_r   <= SPEED_W'(1);
      ptr_r     <= '0;
      idone_r   <= 1'b0;
      st_v_r    <= 1'b0;
      changed_r <= 1'b0;
      pend_r    <= 1'b0;
      ov_r      <= 1'b0;
      cur_vld_r <= '0;
      tgt_vld_r <= '0;
    end else begin
      state_r   <= state_nxt;
      fade_r    <= fade_nxt;
      tick_r    <= tick_nxt;
      ptr_r     <= ptr_nxt;
      idone_r   <= idone_nxt;
      st_v_r    <= st_v_nxt;
      changed_r <= changed_nxt;
      pend_r    <= pend_nxt;
      ov_r      <= ov_nxt;
      if (cfg_we) begin
        speed_r <= cfg_wdata;
      end
      if (cur_we) begin
        cur_vld_r[wr_addr] <= 1'b1;
      end
      if (tgt_we) begin
        tgt_vld_r[wr_addr] <= 1'b1;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    st_idx_r   <= st_idx_nxt;
    pend_idx_r <= pend_idx_nxt;
    o_fading_r <= o_fading_nxt;
    o_entry_r  <= o_entry_nxt;
    o_index_r  <= o_index_nxt;
    o_color_r  <= o_color_nxt;
    o_last_r   <= o_last_nxt;
  end

  // current palette memory
  always_ff @(posedge clk) begin
    if (cur_we) begin
      cur_mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      cur_q_r  <= cur_mem[rd_addr];
      cur_qv_r <= cur_vld_r[rd_addr];
    end
  end

  // target palette memory
  always_ff @(posedge clk) begin
    if (tgt_we) begin
      tgt_mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      tgt_q_r  <= tgt_mem[rd_addr];
      tgt_qv_r <= tgt_vld_r[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/pfs_checker.sv =====
// port-level assertions for the palette fade stepper and their bind
`default_nettype none

module pfs_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic        fading,
  input wire logic        is_entry,
  input wire logic [5:0]  out_index,
  input wire logic [11:0] out_color,
  input wire logic        last
);

  // a stalled result beat keeps its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_index) && $stable(out_color)
      && $stable(last) && $stable(is_entry))
    else $error("result beat changed while stalled");

  // a status beat is the only beat of its request and carries no entry
  a_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !is_entry |-> last && !fading && out_index == 6'd0 && out_color == 12'd0)
    else $error("malformed status beat");

  // palette beats only happen during a fade
  a_entry_fading: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && is_entry |-> fading)
    else $error("palette beat without fading");

  // no request is taken in the middle of a palette upload
  a_no_req_mid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && is_entry && !last |-> !in_ready)
    else $error("request ready during palette upload");

endmodule

bind palette_fade_stepper pfs_checker u_pfs_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_req.ready),
  .out_valid (out_res.valid),
  .out_ready (out_res.ready),
  .fading    (out_res.fading),
  .is_entry  (out_res.is_entry),
  .out_index (out_res.out_index),
  .out_color (out_res.out_color),
  .last      (out_res.last)
);

`default_nettype wire

// ===== sim/palette_fade_checker.sv =====
// checker for the palette fade stepper: predicts result beats and compares them
module palette_fade_checker
  import pfs_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  pfs_req_if                      req_ch,
  pfs_res_if                      res_ch,
  input  wire logic               cfg_we,
  input  wire logic [SPEED_W-1:0] cfg_wdata,
  output int                      fail_count,
  output int                      beats_pending,
  output int                      beats_checked,
  output int                      fade_steps,
  output int                      fade_ends
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic               fading;
    logic               is_entry;
    logic [INDEX_W-1:0] index;
    logic [COLOR_W-1:0] color;
    logic               last;
  } pal_beat_t;

  // predicted palette state
  logic [COLOR_W-1:0] cur_pal [PAL_ENTRIES];
  logic [COLOR_W-1:0] tgt_pal [PAL_ENTRIES];
  logic               fade_on;
  logic [SPEED_W-1:0] tick_cnt;
  logic [SPEED_W-1:0] speed;
  pal_beat_t          expected_beats [$];

  // one fade step of a colour: {moved, next colour}, low bits untouched
  function automatic logic [COLOR_W:0] fade_toward(input logic [COLOR_W-1:0] cur,
                                                   input logic [COLOR_W-1:0] tgt);
    logic [COLOR_W-1:0] nxt;
    logic               moved;
    logic [2:0]         a;
    logic [2:0]         b;
    nxt   = cur;
    moved = 1'b0;
    for (int c = 0; c < NUM_CHAN; c++) begin
      a = cur[4*c+1 +: 3];
      b = tgt[4*c+1 +: 3];
      if (a != b) begin
        moved = 1'b1;
        nxt[4*c+1 +: 3] = (a < b) ? a + 3'd1 : a - 3'd1;
      end
    end
    return {moved, nxt};
  endfunction

  // update the predicted state for one accepted request and queue its beats
  task automatic predict_req(input req_type_t kind, input logic [INDEX_W-1:0] idx,
                             input logic [COLOR_W-1:0] col);
    logic [COLOR_W:0] stepped;
    logic             any_moved;
    pal_beat_t        beat;
    case (kind)
      REQ_WR_CUR: cur_pal[idx] = col;
      REQ_WR_TGT: tgt_pal[idx] = col;
      REQ_START: begin
        fade_on  = 1'b1;
        tick_cnt = '0;
      end
      REQ_TICK: begin
        if (fade_on) begin
          tick_cnt = tick_cnt + 8'd1;
          if (tick_cnt >= speed) begin
            tick_cnt  = '0;
            any_moved = 1'b0;
            for (int i = 0; i < PAL_ENTRIES; i++) begin
              stepped    = fade_toward(cur_pal[i], tgt_pal[i]);
              cur_pal[i] = stepped[COLOR_W-1:0];
              any_moved  = any_moved | stepped[COLOR_W];
            end
            if (!any_moved) begin
              // nothing left to move: single status beat
              fade_on = 1'b0;
              fade_ends++;
              beat = '0;
              beat.last = 1'b1;
              expected_beats.push_back(beat);
            end else begin
              fade_steps++;
              for (int i = 0; i < PAL_ENTRIES; i++) begin
                beat.fading   = 1'b1;
                beat.is_entry = 1'b1;
                beat.index    = INDEX_W'(i);
                beat.color    = cur_pal[i];
                beat.last     = (i == PAL_ENTRIES - 1);
                expected_beats.push_back(beat);
              end
            end
          end
        end
      end
    endcase
  endtask

  task automatic check_field(input string name, input logic [COLOR_W-1:0] want,
                             input logic [COLOR_W-1:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, want, got);
      fail_count++;
    end
  endtask

  // watch both channels and the register port on every rising edge
  always @(posedge clk) begin
    pal_beat_t want;
    if (!rst_n) begin
      for (int i = 0; i < PAL_ENTRIES; i++) begin
        cur_pal[i] = '0;
        tgt_pal[i] = '0;
      end
      fade_on  = 1'b0;
      tick_cnt = '0;
      speed    = 8'd1;
      expected_beats.delete();
    end else begin
      if (cfg_we) speed = cfg_wdata;
      if (res_ch.valid && res_ch.ready) begin
        beats_checked++;
        if (expected_beats.size() == 0) begin
          $error("result beat with nothing expected");
          fail_count++;
        end else begin
          want = expected_beats.pop_front();
          check_field("fading", COLOR_W'(want.fading), COLOR_W'(res_ch.fading));
          check_field("is_entry", COLOR_W'(want.is_entry), COLOR_W'(res_ch.is_entry));
          check_field("out_index", COLOR_W'(want.index), COLOR_W'(res_ch.out_index));
          check_field("out_color", want.color, res_ch.out_color);
          check_field("last", COLOR_W'(want.last), COLOR_W'(res_ch.last));
        end
      end
      if (req_ch.valid && req_ch.ready)
        predict_req(req_type_t'(req_ch.req_type), req_ch.entry_index, req_ch.color);
    end
    beats_pending = expected_beats.size();
  end

endmodule

// ===== sim/palette_fade_stepper_tb.sv =====
// top of the palette fade stepper testbench: clock, reset, stimulus and verdict
module palette_fade_stepper_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import pfs_pkg::*;

  localparam int SETTLE_CYCLES = 150;
  localparam int RAND_ITEMS    = 100;

  logic               clk = 1'b0;
  logic               rst_n;
  logic               cfg_we;
  logic [SPEED_W-1:0] cfg_wdata;

  int                 fail_count;
  int                 beats_pending;
  int                 beats_checked;
  int                 fade_steps;
  int                 fade_ends;

  int                 snd_idle_pct;
  int                 rcv_idle_pct;
  int                 items_sent;
  int                 rand_base;
  int                 run_idx;
  logic [SPEED_W-1:0] cur_speed;

  pfs_req_if req_ch ();
  pfs_res_if res_ch ();

  palette_fade_stepper uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_req   (req_ch),
    .out_res  (res_ch),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  palette_fade_checker chk (
    .clk          (clk),
    .rst_n        (rst_n),
    .req_ch       (req_ch),
    .res_ch       (res_ch),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .fail_count   (fail_count),
    .beats_pending(beats_pending),
    .beats_checked(beats_checked),
    .fade_steps   (fade_steps),
    .fade_ends    (fade_ends)
  );

  always #2 clk = ~clk;

  // result side back-pressure
  always @(negedge clk) begin
    res_ch.ready <= ($urandom_range(0, 99) >= rcv_idle_pct);
  end

  // run limit
  initial begin
    #10_000_000;
    $display("simulation failed");
    $finish;
  end

  task automatic set_idle(input int mode);
    case (mode)
      0: begin
        snd_idle_pct = 21;
        rcv_idle_pct = 76;
      end
      1: begin
        snd_idle_pct = 76;
        rcv_idle_pct = 21;
      end
      default: begin
        snd_idle_pct = 0;
        rcv_idle_pct = 0;
      end
    endcase
  endtask

  // one request beat, with random gaps before it
  task automatic send_req(input req_type_t kind, input logic [INDEX_W-1:0] idx,
                          input logic [COLOR_W-1:0] col);
    @(negedge clk);
    while ($urandom_range(0, 99) < snd_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(negedge clk);
    end
    req_ch.valid       <= 1'b1;
    req_ch.req_type    <= kind;
    req_ch.entry_index <= idx;
    req_ch.color       <= col;
    do @(posedge clk); while (!req_ch.ready);
    items_sent++;
  endtask

  task automatic send_ticks(input int n);
    for (int k = 0; k < n; k++)
      send_req(REQ_TICK, INDEX_W'($urandom_range(0, 63)), COLOR_W'($urandom_range(0, 4095)));
  endtask

  task automatic send_write(input logic [TYPE_W-1:0] kind);
    send_req(req_type_t'(kind), INDEX_W'($urandom_range(0, 63)),
             COLOR_W'($urandom_range(0, 4095)));
  endtask

  // stop sending, wait for all beats and let the block settle
  task automatic drain();
    @(negedge clk);
    req_ch.valid <= 1'b0;
    while (beats_pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_speed(input logic [SPEED_W-1:0] value);
    drain();
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we    <= 1'b0;
    cur_speed = value;
  endtask

  // palette setup, fade start and enough ticks to finish, with some noise mixed in
  task automatic fade_run();
    int n_wr;
    int n_tick;
    int r;
    n_wr = $urandom_range(1, 10);
    for (int k = 0; k < n_wr; k++) begin
      if ($urandom_range(0, 9) == 0) send_ticks(1);
      else send_write(TYPE_W'($urandom_range(0, 1)));
    end
    send_req(REQ_START, INDEX_W'($urandom_range(0, 63)), COLOR_W'($urandom_range(0, 4095)));
    n_tick = 8 * (int'(cur_speed) + 1) + $urandom_range(0, 3);
    for (int k = 0; k < n_tick; k++) begin
      r = $urandom_range(0, 99);
      if (r < 8) send_write(TYPE_W'($urandom_range(0, 1)));
      else if (r < 11) send_req(REQ_START, INDEX_W'($urandom_range(0, 63)),
                                COLOR_W'($urandom_range(0, 4095)));
      else send_ticks(1);
    end
  endtask

  initial begin
    rst_n              = 1'b0;
    cfg_we             = 1'b0;
    cfg_wdata          = '0;
    req_ch.valid       = 1'b0;
    req_ch.req_type    = REQ_WR_CUR;
    req_ch.entry_index = '0;
    req_ch.color       = '0;
    cur_speed          = 8'd1;
    items_sent         = 0;
    set_idle(0);
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;

    // directed: tick while idle, extreme colours and indexes, restart and write mid-fade
    send_ticks(1);
    send_req(REQ_WR_CUR, 6'd0, 12'hFFF);
    send_req(REQ_WR_TGT, 6'd0, 12'h000);
    send_req(REQ_WR_CUR, 6'd63, 12'h111);
    send_req(REQ_WR_TGT, 6'd63, 12'hEEF);
    send_req(REQ_WR_CUR, 6'd21, 12'h5A5);
    send_req(REQ_WR_TGT, 6'd42, 12'hFFF);
    send_req(REQ_START, 6'd0, 12'h000);
    send_ticks(1);
    send_req(REQ_START, 6'd63, 12'hFFF);
    send_req(REQ_WR_TGT, 6'd21, 12'h0F0);
    send_ticks(1);
    send_req(REQ_WR_CUR, 6'd63, 12'hEEE);
    send_ticks(9);

    // speed 0: step on every tick, already settled so the fade ends at once
    write_speed(8'd0);
    send_req(REQ_START, 6'd0, 12'h000);
    send_ticks(1);

    // speed 255: count all the way up before one step
    write_speed(8'd255);
    send_req(REQ_WR_TGT, 6'd7, 12'h002);
    send_req(REQ_START, 6'd0, 12'h000);
    send_ticks(256);

    // random fades over three idle patterns and several speeds
    rand_base = items_sent;
    run_idx   = 0;
    while (items_sent - rand_base < RAND_ITEMS) begin
      set_idle((items_sent - rand_base) < RAND_ITEMS / 3 ? 0 :
               (items_sent - rand_base) < 2 * RAND_ITEMS / 3 ? 1 : 2);
      if (run_idx % 3 == 0)
        write_speed(run_idx == 0 ? 8'd0 : SPEED_W'($urandom_range(1, 3)));
      fade_run();
      run_idx++;
    end

    drain();
    $display("ran %0d requests: %0d fade steps and %0d fade ends", items_sent, fade_steps,
             fade_ends);
    $display("checked %0d result beats at speeds 0 to 255 under three idle patterns",
             beats_checked);
    if (fail_count == 0 && beats_pending == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ===== palette_fade_stepper.f =====
rtl/pfs_pkg.sv
rtl/pfs_if.sv
rtl/palette_fade_stepper.sv
rtl/pfs_checker.sv
sim/palette_fade_checker.sv
sim/palette_fade_stepper_tb.sv
